/* design/dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] MODE_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK   = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT   = 3'd2;
  localparam logic [2:0] MODE_POP_BACK    = 3'd3;
  localparam logic [2:0] MODE_DUMP_FWD    = 3'd4;
  localparam logic [2:0] MODE_DUMP_REV    = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]                   mode;
    logic signed [DATA_WIDTH-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   status;
    logic                         last_of_run;
  } rsp_t;

  // Ring position base + off, where base < DEPTH and off <= DEPTH.
  function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/dq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/double_ended_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DEPTH signed words kept in a single ring memory with
// one write and one registered read port. A push answers with one status
// beat; a push into a full queue is rejected with status full.
// A pop first starts the memory read, then moves the word from the read
// register to the output once the output is free. A dump of N stored
// words starts the first read, then sends one word per cycle while the
// output is not stalled, the final beat marked last_of_run; a pop or dump
// on an empty queue answers with one empty beat. Requests are stalled
// while a pop or dump is in progress and while a result is held back by
// the output stall. Codes six and seven are taken and ignored.
module double_ended_queue_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire dq_pkg::req_t  req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output dq_pkg::rsp_t       rsp
);

  import dq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]            state, state_next;
  logic [ADDR_W-1:0]     front, front_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic                  dump_reverse, dump_reverse_next;

  logic                  out_free;
  logic                  accept;
  logic                  rsp_load;
  rsp_t                  rsp_next;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  is_empty;
  logic                  is_full;
  logic [CNT_W-1:0]      idx_inc;
  logic                  dump_last;

  dq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(req.push_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CNT_W'(DEPTH));
  assign idx_inc   = idx + CNT_W'(1);
  assign dump_last = (idx_inc == count);

  always_comb begin
    state_next        = state;
    front_next        = front;
    count_next        = count;
    idx_next          = idx;
    dump_reverse_next = dump_reverse;
    wr_en             = 1'b0;
    wr_addr           = front;
    rd_en             = 1'b0;
    rd_addr           = front;
    rsp_load          = 1'b0;
    rsp_next          = '{result_value: '0, status: STATUS_OK, last_of_run: 1'b1};

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              rsp_load = 1'b1;
              if (is_full) begin
                rsp_next.status = STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
                if (req.mode == MODE_PUSH_FRONT) begin
                  front_next = (front == '0) ? ADDR_W'(DEPTH - 1) : front - ADDR_W'(1);
                  wr_addr    = front_next;
                end else begin
                  wr_addr = ring_add(front, count);
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (is_empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = count - CNT_W'(1);
                state_next = S_POP;
                if (req.mode == MODE_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = ring_add(front, CNT_W'(1));
                end else begin
                  rd_addr = ring_add(front, count - CNT_W'(1));
                end
                // Emptying the queue resets both ends.
                if (count == CNT_W'(1)) begin
                  front_next = '0;
                end
              end
            end
            MODE_DUMP_FWD, MODE_DUMP_REV: begin
              if (is_empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_EMPTY;
              end else begin
                rd_en             = 1'b1;
                idx_next          = '0;
                dump_reverse_next = (req.mode == MODE_DUMP_REV);
                state_next        = S_DUMP;
                rd_addr = ring_add(front, (req.mode == MODE_DUMP_REV) ?
                                          count - CNT_W'(1) : '0);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          rsp_load              = 1'b1;
          rsp_next.result_value = rd_data;
          state_next            = S_IDLE;
        end
      end
      S_DUMP: begin
        // The word at position idx sits in the read register; fetch the next
        // one in the same cycle that this one moves to the output.
        if (out_free) begin
          rsp_load              = 1'b1;
          rsp_next.result_value = rd_data;
          rsp_next.last_of_run  = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            idx_next = idx_inc;
            rd_addr  = ring_add(front, dump_reverse ?
                                       count - CNT_W'(1) - idx_inc : idx_inc);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      front        <= '0;
      count        <= '0;
      idx          <= '0;
      dump_reverse <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      front        <= front_next;
      count        <= count_next;
      idx          <= idx_next;
      dump_reverse <= dump_reverse_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
